[hdl/tywa_pkg.sv]
// Package for the tilt and yaw window averager.
// Holds the sequencer state type, unit status type, fixed widths and the arctangent table.
// Used by the units and the top level of the block; depends on nothing.
package tywa_pkg;

	// Fixed widths of the datapath.
	localparam int unsigned ANGLE_W  = 14;
	localparam int unsigned CORDIC_W = 36;
	localparam int unsigned ZACC_W   = 26;
	localparam int unsigned SUM_W    = 40;
	localparam int unsigned COUNT_W  = 7;
	localparam int unsigned TAB_W    = 5;
	localparam int unsigned TAB_LEN  = 24;

	// Angle limit of +-90 degrees in 1/64 degree.
	localparam logic signed [ANGLE_W-1:0] ANGLE_LIMIT = 14'sd5760;

	// Register indexes of the configuration port.
	localparam logic REG_SAMPLE_PERIOD = 1'b0;
	localparam logic REG_WINDOW_LENGTH = 1'b1;

	// Status of an iterative unit toward the sequencer.
	typedef struct packed {
		logic busy;
		logic done;
	} unit_stat_t;

	// Sequencer states.
	typedef enum logic [3:0] {
		ST_IDLE,
		ST_YAW_MUL,
		ST_YAW_ACC,
		ST_YAW_RND,
		ST_SQ_A,
		ST_SQ_B,
		ST_SQ_SUM,
		ST_SQRT_GO,
		ST_SQRT,
		ST_CORDIC_GO,
		ST_CORDIC,
		ST_ANGLE,
		ST_ACCUM,
		ST_DIV_GO,
		ST_DIV,
		ST_OUT
	} state_t;

	// atan(2^-i) in units of 2^-16 degree.
	function automatic logic [22:0] atan_val(input logic [TAB_W-1:0] idx);
		logic [22:0] v;
		case (idx)
			5'd0:    v = 23'd2949120;
			5'd1:    v = 23'd1740967;
			5'd2:    v = 23'd919879;
			5'd3:    v = 23'd466945;
			5'd4:    v = 23'd234379;
			5'd5:    v = 23'd117304;
			5'd6:    v = 23'd58666;
			5'd7:    v = 23'd29335;
			5'd8:    v = 23'd14668;
			5'd9:    v = 23'd7334;
			5'd10:   v = 23'd3667;
			5'd11:   v = 23'd1833;
			5'd12:   v = 23'd917;
			5'd13:   v = 23'd458;
			5'd14:   v = 23'd229;
			5'd15:   v = 23'd115;
			5'd16:   v = 23'd57;
			5'd17:   v = 23'd29;
			5'd18:   v = 23'd14;
			5'd19:   v = 23'd7;
			5'd20:   v = 23'd4;
			5'd21:   v = 23'd2;
			5'd22:   v = 23'd1;
			default: v = 23'd0;
		endcase
		return v;
	endfunction

endpackage

[hdl/tywa_if.sv]
// Channel interfaces of the tilt and yaw window averager: sample in, result out.
// Each carries valid, ready and the payload word; depends on nothing.
interface tywa_sample_if;
	logic               valid;
	logic               ready;
	logic signed [15:0] accel_x;
	logic signed [15:0] accel_y;
	logic signed [15:0] accel_z;
	logic signed [15:0] rate_z;

	modport source (output valid, accel_x, accel_y, accel_z, rate_z, input ready);
	modport sink (input valid, accel_x, accel_y, accel_z, rate_z, output ready);
endinterface

interface tywa_result_if;
	logic               valid;
	logic               ready;
	logic signed [13:0] mean_roll;
	logic signed [13:0] mean_pitch;
	logic signed [31:0] mean_yaw;

	modport source (output valid, mean_roll, mean_pitch, mean_yaw, input ready);
	modport sink (input valid, mean_roll, mean_pitch, mean_yaw, output ready);
endinterface

[hdl/tywa_isqrt.sv]
// Bit-serial integer square root: floor(sqrt(radicand * 2^32)), one root bit per cycle.
// Depends on tywa_pkg for the unit status type.
module tywa_isqrt (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  start,
	input  logic [31:0]           radicand,
	output tywa_pkg::unit_stat_t  stat,
	output logic [31:0]           root
);

	logic [63:0] v_q;
	logic [34:0] r_q;
	logic [31:0] q_q;
	logic [4:0]  cnt_q;
	logic        busy_q;
	logic        done_q;
	logic [34:0] r_in;
	logic [34:0] trial;
	logic        take;

	// One digit step: bring down two radicand bits and try the next root bit.
	always_comb begin
		r_in  = {r_q[32:0], v_q[63:62]};
		trial = {1'b0, q_q, 2'b01};
		take  = (r_in >= trial);
	end

	// Control of the iteration.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 5'd1;
				if (cnt_q == 5'd31) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// Datapath of the iteration.
	always_ff @(posedge clk) begin
		if (start) begin
			v_q <= {radicand, 32'd0};
			r_q <= '0;
			q_q <= '0;
		end else if (busy_q) begin
			v_q <= {v_q[61:0], 2'b00};
			if (take) begin
				r_q <= r_in - trial;
				q_q <= {q_q[30:0], 1'b1};
			end else begin
				r_q <= r_in;
				q_q <= {q_q[30:0], 1'b0};
			end
		end
	end

	assign stat.busy = busy_q;
	assign stat.done = done_q;
	assign root      = q_q;

endmodule

[hdl/tywa_cordic.sv]
// Vectoring CORDIC that turns (x, y) into atan(y / x) in 1/64 degree, one rotation a cycle.
// Depends on tywa_pkg for widths, the arctangent table and the unit status type.
module tywa_cordic #(
	parameter int unsigned ITER = 16
) (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   start,
	input  logic signed [tywa_pkg::CORDIC_W-1:0]   x0,
	input  logic signed [tywa_pkg::CORDIC_W-1:0]   y0,
	output tywa_pkg::unit_stat_t                   stat,
	output logic signed [tywa_pkg::ANGLE_W-1:0]    angle
);

	localparam int unsigned IW = (ITER > 1) ? $clog2(ITER) : 1;

	logic signed [tywa_pkg::CORDIC_W-1:0] x_q;
	logic signed [tywa_pkg::CORDIC_W-1:0] y_q;
	logic signed [tywa_pkg::ZACC_W-1:0]   z_q;
	logic [IW-1:0]                         i_q;
	logic                                  busy_q;
	logic                                  done_q;
	logic signed [tywa_pkg::CORDIC_W-1:0] dx;
	logic signed [tywa_pkg::CORDIC_W-1:0] dy;
	logic signed [tywa_pkg::ZACC_W-1:0]   za;
	logic signed [tywa_pkg::ZACC_W:0]     zr_sum;
	logic signed [tywa_pkg::ZACC_W-10:0]  zr;
	logic signed [tywa_pkg::ANGLE_W-1:0]  angle_c;

	// Shifted cross terms and the table angle of this step.
	always_comb begin
		dx = y_q >>> i_q;
		dy = x_q >>> i_q;
		za = tywa_pkg::ZACC_W'(tywa_pkg::atan_val(tywa_pkg::TAB_W'(i_q)));
	end

	// Round the accumulated angle to the nearest 1/64 degree, ties upward, then clamp to +-90 degrees.
	always_comb begin
		zr_sum = (tywa_pkg::ZACC_W+1)'(z_q) + (tywa_pkg::ZACC_W+1)'(512);
		zr     = (tywa_pkg::ZACC_W-9)'(zr_sum >>> 10);
		if (zr > (tywa_pkg::ZACC_W-9)'(tywa_pkg::ANGLE_LIMIT)) begin
			angle_c = tywa_pkg::ANGLE_LIMIT;
		end else if (zr < -(tywa_pkg::ZACC_W-9)'(tywa_pkg::ANGLE_LIMIT)) begin
			angle_c = -tywa_pkg::ANGLE_LIMIT;
		end else begin
			angle_c = tywa_pkg::ANGLE_W'(zr);
		end
	end

	// Control of the rotations.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			i_q    <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				i_q    <= '0;
			end else if (busy_q) begin
				i_q <= i_q + IW'(1);
				if (i_q == IW'(ITER-1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// One rotation toward the x axis per cycle.
	always_ff @(posedge clk) begin
		if (start) begin
			x_q <= x0;
			y_q <= y0;
			z_q <= '0;
		end else if (busy_q) begin
			if (y_q > 0) begin
				x_q <= x_q + dx;
				y_q <= y_q - dy;
				z_q <= z_q + za;
			end else begin
				x_q <= x_q - dx;
				y_q <= y_q + dy;
				z_q <= z_q - za;
			end
		end
	end

	// The angle holds steady once the rotations stop, so it is valid while done is high.
	assign stat.busy = busy_q;
	assign stat.done = done_q;
	assign angle     = angle_c;

endmodule

[hdl/tywa_rdiv.sv]
// Iterative rounded divider: round(sum / count), ties away from zero, one quotient bit a cycle.
// Depends on tywa_pkg for widths and the unit status type.
module tywa_rdiv (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 start,
	input  logic signed [tywa_pkg::SUM_W-1:0]    sum,
	input  logic [tywa_pkg::COUNT_W-1:0]         divisor,
	output tywa_pkg::unit_stat_t                 stat,
	output logic [31:0]                          quotient
);

	localparam int unsigned DW = tywa_pkg::SUM_W + 1;
	localparam int unsigned CW = $clog2(DW);

	logic [DW-1:0]                  dvd_q;
	logic [tywa_pkg::COUNT_W-1:0]   rem_q;
	logic [CW-1:0]                  cnt_q;
	logic                           neg_q;
	logic                           busy_q;
	logic                           done_q;
	logic signed [DW-1:0]           s_ext;
	logic [DW-1:0]                  mag;
	logic [tywa_pkg::COUNT_W:0]     r_in;
	logic                           take;
	logic [31:0]                    q_lo;

	// Magnitude plus half the divisor, so that truncation rounds to nearest.
	always_comb begin
		s_ext = DW'(sum);
		mag   = (sum < 0) ? DW'(-s_ext) : DW'(s_ext);
		mag   = mag + DW'(divisor >> 1);
	end

	// Restoring step: shift in one dividend bit and try to subtract.
	always_comb begin
		r_in = {rem_q, dvd_q[DW-1]};
		take = (r_in >= {1'b0, divisor});
		q_lo = dvd_q[31:0];
	end

	// Control of the iteration.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + CW'(1);
				if (cnt_q == CW'(DW-1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// Quotient bits collect in the low end of the dividend register.
	always_ff @(posedge clk) begin
		if (start) begin
			dvd_q <= mag;
			rem_q <= '0;
			neg_q <= (sum < 0);
		end else if (busy_q) begin
			if (take) begin
				rem_q <= tywa_pkg::COUNT_W'(r_in - {1'b0, divisor});
				dvd_q <= {dvd_q[DW-2:0], 1'b1};
			end else begin
				rem_q <= tywa_pkg::COUNT_W'(r_in);
				dvd_q <= {dvd_q[DW-2:0], 1'b0};
			end
		end
	end

	assign stat.busy = busy_q;
	assign stat.done = done_q;
	assign quotient  = neg_q ? (~q_lo + 32'd1) : q_lo;

endmodule

[hdl/tilt_yaw_window_averager.sv]
// Top level of the tilt and yaw window averager: sequencer, shared multiplier, state and ports.
// Depends on tywa_pkg, tywa_if, tywa_isqrt, tywa_cordic and tywa_rdiv.
//
//  channel  | dir | handshake     | word
//  ---------+-----+---------------+---------------------------------------------
//  sample   | in  | valid/ready   | accel_x, accel_y, accel_z, rate_z (16 b each)
//  result   | out | valid/ready   | mean_roll, mean_pitch (14 b), mean_yaw (32 b)
//  config   | in  | APB, pready=1 | sample_period at 0x0, window_length at 0x4
//
// A sample first takes the yaw steps (multiply, accumulate, round), then two tilt angles in turn,
// each with the squares and their sum, the square root (start, root bits, done),
// the CORDIC run and storing the angle, and finally the update of the sums.
// A zero numerator or denominator skips the CORDIC.
// A sample that closes a window then runs the shared divider for roll, pitch and yaw in turn.
// sample.ready is high only while the sequencer is idle.
// A finished result waits in the output register; the next sample is taken meanwhile
// and stalls only if it closes a window before the waiting word is taken.
// Reset clears all sums, the yaw accumulator and the count, and restores the registers.
module tilt_yaw_window_averager #(
	parameter int unsigned ANGLE_ITERATIONS = 16,
	parameter int unsigned MAX_WINDOW       = 64
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          psel,
	input  logic          penable,
	input  logic          pwrite,
	input  logic [2:0]    paddr,
	input  logic [31:0]   pwdata,
	output logic [31:0]   prdata,
	output logic          pready,
	tywa_sample_if.sink   sample,
	tywa_result_if.source result
);

	localparam int unsigned EFF_W = $clog2(MAX_WINDOW + 1);
	localparam int unsigned WC_W  = (EFF_W > tywa_pkg::COUNT_W) ? EFF_W : tywa_pkg::COUNT_W;

	tywa_pkg::state_t state_q, state_d;

	logic [15:0]                          sample_period_q;
	logic [tywa_pkg::COUNT_W-1:0]         window_length_q;
	logic signed [15:0]                   ax_q, ay_q, az_q, rz_q;
	logic signed [16:0]                   mul_a, mul_b;
	logic signed [33:0]                   prod_q;
	logic [31:0]                          sq_q;
	logic signed [47:0]                   acc_q;
	logic signed [31:0]                   yaw_q;
	logic signed [23:0]                   roll_sum_q, pitch_sum_q;
	logic signed [39:0]                   yaw_sum_q;
	logic [tywa_pkg::COUNT_W-1:0]         count_q;
	logic                                 pitch_phase_q;
	logic [1:0]                           div_sel_q;
	logic signed [tywa_pkg::ANGLE_W-1:0]  angle_q, roll_q, pitch_q;
	logic signed [13:0]                   res_roll_q, res_pitch_q;
	logic signed [31:0]                   res_yaw_q;
	logic                                 out_valid_q;
	logic signed [13:0]                   out_roll_q, out_pitch_q;
	logic signed [31:0]                   out_yaw_q;

	logic signed [16:0]                   num;
	logic signed [15:0]                   sq_first;
	logic signed [48:0]                   acc_sum;
	logic signed [47:0]                   acc_sat;
	logic signed [48:0]                   yaw_rnd_sum;
	logic signed [34:0]                   yaw_sh;
	logic signed [31:0]                   yaw_sat;
	logic [tywa_pkg::COUNT_W-1:0]         count_next;
	logic [WC_W-1:0]                      eff;
	logic                                 emit;
	logic signed [tywa_pkg::SUM_W-1:0]    div_sum;
	logic                                 sqrt_start, cordic_start, div_start;
	logic                                 cfg_wr;
	logic                                 out_free;
	tywa_pkg::unit_stat_t                 sqrt_stat, cordic_stat, div_stat;
	logic [31:0]                          root;
	logic signed [tywa_pkg::ANGLE_W-1:0]  cordic_angle;
	logic [31:0]                          div_q;
	logic signed [tywa_pkg::CORDIC_W-1:0] cx0, cy0;

	// Configuration port.
	assign pready = 1'b1;
	assign cfg_wr = psel & penable & pwrite;
	assign prdata = (paddr[2] == tywa_pkg::REG_WINDOW_LENGTH)
		? {25'd0, window_length_q} : {16'd0, sample_period_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sample_period_q <= 16'd6554;
			window_length_q <= 7'd10;
		end else if (cfg_wr) begin
			if (paddr[2] == tywa_pkg::REG_SAMPLE_PERIOD) begin
				sample_period_q <= pwdata[15:0];
			end else begin
				window_length_q <= pwdata[tywa_pkg::COUNT_W-1:0];
			end
		end
	end

	// Numerator and first square operand of the tilt angle in work.
	always_comb begin
		num      = pitch_phase_q ? -17'(ax_q) : 17'(ay_q);
		sq_first = pitch_phase_q ? ay_q : ax_q;
	end

	// Shared multiplier operand selection.
	always_comb begin
		mul_a = 17'(sq_first);
		mul_b = 17'(sq_first);
		if (state_q == tywa_pkg::ST_YAW_MUL) begin
			mul_a = 17'(rz_q);
			mul_b = $signed({1'b0, sample_period_q});
		end else if (state_q == tywa_pkg::ST_SQ_B) begin
			mul_a = 17'(az_q);
			mul_b = 17'(az_q);
		end
	end

	always_ff @(posedge clk) begin
		prod_q <= mul_a * mul_b;
	end

	// Saturating yaw accumulation and rounding of the yaw angle.
	always_comb begin
		acc_sum = 49'(acc_q) + 49'(prod_q);
		if (acc_sum > 49'sh0_7FFF_FFFF_FFFF) begin
			acc_sat = 48'sh7FFF_FFFF_FFFF;
		end else if (acc_sum < -49'sh0_8000_0000_0000) begin
			acc_sat = -48'sh8000_0000_0000;
		end else begin
			acc_sat = 48'(acc_sum);
		end
		yaw_rnd_sum = 49'(acc_q) + 49'sd8192;
		yaw_sh      = 35'(yaw_rnd_sum >>> 14);
		if (yaw_sh > 35'sh0_7FFF_FFFF) begin
			yaw_sat = 32'sh7FFF_FFFF;
		end else if (yaw_sh < -35'sh0_8000_0000) begin
			yaw_sat = -32'sh8000_0000;
		end else begin
			yaw_sat = 32'(yaw_sh);
		end
	end

	// Window bookkeeping: effective length is the register clamped to one..MAX_WINDOW.
	always_comb begin
		count_next = count_q + tywa_pkg::COUNT_W'(1);
		if (window_length_q == '0) begin
			eff = WC_W'(1);
		end else if (WC_W'(window_length_q) > WC_W'(MAX_WINDOW)) begin
			eff = WC_W'(MAX_WINDOW);
		end else begin
			eff = WC_W'(window_length_q);
		end
		emit = (count_next != '0) && (WC_W'(count_next) >= eff);
	end

	// Sum handed to the divider.
	always_comb begin
		case (div_sel_q)
			2'd0:    div_sum = tywa_pkg::SUM_W'(roll_sum_q);
			2'd1:    div_sum = tywa_pkg::SUM_W'(pitch_sum_q);
			default: div_sum = yaw_sum_q;
		endcase
	end

	assign cx0      = $signed({4'd0, root});
	assign cy0      = tywa_pkg::CORDIC_W'(num) <<< 16;
	assign out_free = !out_valid_q || result.ready;

	// Sequencer next state and unit starts.
	always_comb begin
		state_d      = state_q;
		sqrt_start   = 1'b0;
		cordic_start = 1'b0;
		div_start    = 1'b0;
		unique case (state_q)
			tywa_pkg::ST_IDLE: begin
				if (sample.valid) state_d = tywa_pkg::ST_YAW_MUL;
			end
			tywa_pkg::ST_YAW_MUL:   state_d = tywa_pkg::ST_YAW_ACC;
			tywa_pkg::ST_YAW_ACC:   state_d = tywa_pkg::ST_YAW_RND;
			tywa_pkg::ST_YAW_RND:   state_d = tywa_pkg::ST_SQ_A;
			tywa_pkg::ST_SQ_A:      state_d = tywa_pkg::ST_SQ_B;
			tywa_pkg::ST_SQ_B:      state_d = tywa_pkg::ST_SQ_SUM;
			tywa_pkg::ST_SQ_SUM:    state_d = tywa_pkg::ST_SQRT_GO;
			tywa_pkg::ST_SQRT_GO: begin
				sqrt_start = 1'b1;
				state_d    = tywa_pkg::ST_SQRT;
			end
			tywa_pkg::ST_SQRT: begin
				if (sqrt_stat.done) state_d = tywa_pkg::ST_CORDIC_GO;
			end
			tywa_pkg::ST_CORDIC_GO: begin
				if (num == '0 || root == '0) begin
					state_d = tywa_pkg::ST_ANGLE;
				end else begin
					cordic_start = 1'b1;
					state_d      = tywa_pkg::ST_CORDIC;
				end
			end
			tywa_pkg::ST_CORDIC: begin
				if (cordic_stat.done) state_d = tywa_pkg::ST_ANGLE;
			end
			tywa_pkg::ST_ANGLE: begin
				state_d = pitch_phase_q ? tywa_pkg::ST_ACCUM : tywa_pkg::ST_SQ_A;
			end
			tywa_pkg::ST_ACCUM: begin
				state_d = emit ? tywa_pkg::ST_DIV_GO : tywa_pkg::ST_IDLE;
			end
			tywa_pkg::ST_DIV_GO: begin
				div_start = 1'b1;
				state_d   = tywa_pkg::ST_DIV;
			end
			tywa_pkg::ST_DIV: begin
				if (div_stat.done) begin
					state_d = (div_sel_q == 2'd2) ? tywa_pkg::ST_OUT : tywa_pkg::ST_DIV_GO;
				end
			end
			tywa_pkg::ST_OUT: begin
				if (out_free) state_d = tywa_pkg::ST_IDLE;
			end
			default: state_d = tywa_pkg::ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= tywa_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	assign sample.ready = (state_q == tywa_pkg::ST_IDLE);

	// Sample capture and per-sample work registers.
	always_ff @(posedge clk) begin
		if (state_q == tywa_pkg::ST_IDLE && sample.valid) begin
			ax_q <= sample.accel_x;
			ay_q <= sample.accel_y;
			az_q <= sample.accel_z;
			rz_q <= sample.rate_z;
		end
		if (state_q == tywa_pkg::ST_YAW_RND) yaw_q <= yaw_sat;
		if (state_q == tywa_pkg::ST_SQ_B) sq_q <= prod_q[31:0];
		if (state_q == tywa_pkg::ST_SQ_SUM) sq_q <= sq_q + prod_q[31:0];
		if (state_q == tywa_pkg::ST_CORDIC_GO) begin
			if (num == '0) begin
				angle_q <= '0;
			end else if (root == '0) begin
				angle_q <= (num > 0) ? tywa_pkg::ANGLE_LIMIT : -tywa_pkg::ANGLE_LIMIT;
			end
		end
		if (state_q == tywa_pkg::ST_CORDIC && cordic_stat.done) angle_q <= cordic_angle;
		if (state_q == tywa_pkg::ST_ANGLE) begin
			if (pitch_phase_q) begin
				pitch_q <= angle_q;
			end else begin
				roll_q <= angle_q;
			end
		end
		if (state_q == tywa_pkg::ST_DIV && div_stat.done) begin
			case (div_sel_q)
				2'd0:    res_roll_q  <= div_q[13:0];
				2'd1:    res_pitch_q <= div_q[13:0];
				default: res_yaw_q   <= div_q;
			endcase
		end
	end

	// Block state: accumulator, window sums, count and sequencing indexes.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q         <= '0;
			roll_sum_q    <= '0;
			pitch_sum_q   <= '0;
			yaw_sum_q     <= '0;
			count_q       <= '0;
			pitch_phase_q <= 1'b0;
			div_sel_q     <= '0;
		end else begin
			if (state_q == tywa_pkg::ST_YAW_ACC) acc_q <= acc_sat;
			if (state_q == tywa_pkg::ST_YAW_RND) pitch_phase_q <= 1'b0;
			if (state_q == tywa_pkg::ST_ANGLE) pitch_phase_q <= 1'b1;
			if (state_q == tywa_pkg::ST_ACCUM) begin
				roll_sum_q  <= roll_sum_q + 24'(roll_q);
				pitch_sum_q <= pitch_sum_q + 24'(pitch_q);
				yaw_sum_q   <= yaw_sum_q + 40'(yaw_q);
				count_q     <= count_next;
				div_sel_q   <= '0;
			end
			if (state_q == tywa_pkg::ST_DIV && div_stat.done) div_sel_q <= div_sel_q + 2'd1;
			if (state_q == tywa_pkg::ST_OUT && out_free) begin
				roll_sum_q  <= '0;
				pitch_sum_q <= '0;
				yaw_sum_q   <= '0;
				count_q     <= '0;
			end
		end
	end

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (state_q == tywa_pkg::ST_OUT && out_free) begin
			out_valid_q <= 1'b1;
		end else if (result.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == tywa_pkg::ST_OUT && out_free) begin
			out_roll_q  <= res_roll_q;
			out_pitch_q <= res_pitch_q;
			out_yaw_q   <= res_yaw_q;
		end
	end

	assign result.valid      = out_valid_q;
	assign result.mean_roll  = out_roll_q;
	assign result.mean_pitch = out_pitch_q;
	assign result.mean_yaw   = out_yaw_q;

	tywa_isqrt u_isqrt (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (sqrt_start),
		.radicand (sq_q),
		.stat     (sqrt_stat),
		.root     (root)
	);

	tywa_cordic #(
		.ITER (ANGLE_ITERATIONS)
	) u_cordic (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (cordic_start),
		.x0     (cx0),
		.y0     (cy0),
		.stat   (cordic_stat),
		.angle  (cordic_angle)
	);

	tywa_rdiv u_rdiv (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.sum      (div_sum),
		.divisor  (count_q),
		.stat     (div_stat),
		.quotient (div_q)
	);

endmodule

[hdl/tywa_checker.sv]
// Port-level checks of the tilt and yaw window averager, attached by bind.
// Depends on the top level's ports only.
module tywa_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        s_valid,
	input logic        s_ready,
	input logic        r_valid,
	input logic        r_ready,
	input logic [13:0] r_roll,
	input logic        pready
);

	// An offered result word stays put until the sink takes it.
	a_result_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(r_valid && !r_ready) |=> (r_valid && $stable(r_roll)))
		else $error("result word changed while stalled");

	// Every sample keeps the block busy for at least the next cycle.
	a_busy_after_take: assert property (@(posedge clk) disable iff (!arst_n)
		(s_valid && s_ready) |=> !s_ready)
		else $error("sample taken while previous still in work");

	// A new result appears only at the end of sample work.
	a_result_after_work: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(r_valid) |-> $past(!s_ready))
		else $error("result appeared without sample work");

	// No result is shown during reset.
	a_reset_quiet: assert property (@(posedge clk) !arst_n |-> !r_valid)
		else $error("result valid during reset");

	// The configuration port never waits.
	a_pready: assert property (@(posedge clk) disable iff (!arst_n) pready)
		else $error("pready low");

endmodule

bind tilt_yaw_window_averager tywa_checker u_tywa_checker (
	.clk     (clk),
	.arst_n  (arst_n),
	.s_valid (sample.valid),
	.s_ready (sample.ready),
	.r_valid (result.valid),
	.r_ready (result.ready),
	.r_roll  (result.mean_roll),
	.pready  (pready)
);
